FILE: hw/rtl/ifr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifr_pkg: shared definitions for the info frame receiver
// Byte codes, status codes, length cap and the result record.
// ----------------------------------------------------------------------------
package ifr_pkg;

  localparam int MAX_PAYLOAD = 2047;
  localparam int LEN_W = 11;

  localparam logic [LEN_W-1:0] COUNT_CAP =
    (MAX_PAYLOAD < 2047) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(2047);

  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_FLAG    = 8'h5E;
  localparam logic [7:0] ESC_ESC     = 8'h5D;
  localparam logic [7:0] SEQ_BIT     = 8'h80;
  localparam logic [7:0] RR_BASE     = 8'hAA;
  localparam logic [7:0] REJ_BASE    = 8'h54;
  localparam logic [7:0] ADDR_RESET  = 8'h03;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_BAD_DATA = 2'd2;
  localparam logic [1:0] ST_BAD_HDR  = 2'd3;

  typedef struct packed {
    logic             out_kind;
    logic [7:0]       payload_byte;
    logic [1:0]       status;
    logic [7:0]       reply_control;
    logic [LEN_W-1:0] payload_length;
  } ifr_result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ifr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifr_in_if: received byte channel
// Valid/ready request channel carrying one raw serial byte.
// ----------------------------------------------------------------------------
interface ifr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ifr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifr_out_if: result channel
// Valid/ready request channel carrying a payload byte or a frame verdict.
// ----------------------------------------------------------------------------
interface ifr_out_if
  import ifr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             out_kind;
  logic [7:0]       payload_byte;
  logic [1:0]       status;
  logic [7:0]       reply_control;
  logic [LEN_W-1:0] payload_length;

  modport source (output valid, output out_kind, output payload_byte, output status,
                  output reply_control, output payload_length, input ready);
  modport sink   (input valid, input out_kind, input payload_byte, input status,
                  input reply_control, input payload_length, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ifr_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifr_core: frame parser
// Header hunt, BCC1 check, destuffing with one-byte hold, BCC2 verdict.
// ----------------------------------------------------------------------------
module ifr_core
  import ifr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        accept,
  input  wire logic [7:0]  rx_byte,
  output ifr_result_t      res,
  output logic             res_valid
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_FLAG = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_CTRL = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  logic [7:0]       addr_r;
  logic [2:0]       phase_r, phase_nxt;
  logic             seq_r, seq_nxt;
  logic             dup_r, dup_nxt;
  logic [7:0]       hcheck_r, hcheck_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             held_vld_r, held_vld_nxt;
  logic             esc_r, esc_nxt;
  logic [7:0]       parity_r, parity_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;

  logic [7:0]       ctl;
  logic             emit;
  logic [7:0]       emit_byte;
  logic [LEN_W-1:0] count_inc;

  assign ctl       = seq_r ? SEQ_BIT : 8'h00;
  assign count_inc = (count_r < COUNT_CAP) ? count_r + LEN_W'(1) : count_r;

  // destuff the held byte
  always_comb begin
    emit      = 1'b0;
    emit_byte = held_r;
    if (esc_r && held_r == ESC_ESC) begin
      emit      = 1'b1;
      emit_byte = ESC_BYTE;
    end else if (esc_r && held_r == ESC_FLAG) begin
      emit      = 1'b1;
      emit_byte = FLAG_BYTE;
    end else if (held_r != ESC_BYTE) begin
      emit      = 1'b1;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    seq_nxt      = seq_r;
    dup_nxt      = dup_r;
    hcheck_nxt   = hcheck_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    esc_nxt      = esc_r;
    parity_nxt   = parity_r;
    count_nxt    = count_r;
    res_valid    = 1'b0;
    res          = '0;

    unique case (phase_r)
      PH_FLAG: begin
        if (rx_byte == FLAG_BYTE)    phase_nxt = PH_FLAG;
        else if (rx_byte == addr_r)  phase_nxt = PH_ADDR;
        else                         phase_nxt = PH_HUNT;
      end
      PH_ADDR: begin
        if (rx_byte == FLAG_BYTE) begin
          phase_nxt = PH_FLAG;
        end else if (rx_byte == ctl) begin
          seq_nxt    = ~seq_r;
          dup_nxt    = 1'b0;
          hcheck_nxt = rx_byte ^ addr_r;
          phase_nxt  = PH_CTRL;
        end else if (rx_byte == (ctl ^ SEQ_BIT)) begin
          dup_nxt    = 1'b1;
          hcheck_nxt = rx_byte ^ addr_r;
          phase_nxt  = PH_CTRL;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (rx_byte == FLAG_BYTE) begin
          phase_nxt = PH_FLAG;
        end else if (rx_byte == hcheck_r) begin
          phase_nxt    = PH_DATA;
          held_nxt     = 8'h00;
          held_vld_nxt = 1'b0;
          esc_nxt      = 1'b0;
          parity_nxt   = 8'h00;
          count_nxt    = '0;
        end else begin
          res_valid        = 1'b1;
          res.out_kind     = KIND_VERDICT;
          res.status       = ST_BAD_HDR;
          phase_nxt        = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (rx_byte == FLAG_BYTE) begin
          res_valid          = 1'b1;
          res.out_kind       = KIND_VERDICT;
          res.payload_length = count_r;
          if (parity_r == held_r) begin
            res.reply_control = RR_BASE + {7'd0, seq_r};
            res.status        = dup_r ? ST_DUP : ST_GOOD;
          end else begin
            // sequence flips back before REJ is formed
            seq_nxt           = ~seq_r;
            res.reply_control = REJ_BASE + {7'd0, ~seq_r};
            res.status        = ST_BAD_DATA;
          end
          held_vld_nxt = 1'b0;
          esc_nxt      = 1'b0;
          phase_nxt    = PH_HUNT;
        end else begin
          if (held_vld_r) begin
            esc_nxt = !esc_r && held_r == ESC_BYTE;
            if (esc_r && held_r == ESC_BYTE && !emit) esc_nxt = 1'b1;
            if (emit) begin
              parity_nxt         = parity_r ^ emit_byte;
              count_nxt          = count_inc;
              res_valid          = 1'b1;
              res.out_kind       = KIND_PAYLOAD;
              res.payload_byte   = emit_byte;
              res.payload_length = count_inc;
            end
          end
          held_nxt     = rx_byte;
          held_vld_nxt = 1'b1;
        end
      end
      default: begin
        phase_nxt = (rx_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= ADDR_RESET;
      phase_r    <= PH_HUNT;
      seq_r      <= 1'b0;
      dup_r      <= 1'b0;
      hcheck_r   <= 8'h00;
      held_r     <= 8'h00;
      held_vld_r <= 1'b0;
      esc_r      <= 1'b0;
      parity_r   <= 8'h00;
      count_r    <= '0;
    end else begin
      if (cfg_we) addr_r <= cfg_wdata;
      if (accept) begin
        phase_r    <= phase_nxt;
        seq_r      <= seq_nxt;
        dup_r      <= dup_nxt;
        hcheck_r   <= hcheck_nxt;
        held_r     <= held_nxt;
        held_vld_r <= held_vld_nxt;
        esc_r      <= esc_nxt;
        parity_r   <= parity_nxt;
        count_r    <= count_nxt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ifr_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifr_out_skid: result register with skid stage
// Two-entry buffer so input acceptance does not depend on the sink this cycle.
// ----------------------------------------------------------------------------
module ifr_out_skid
  import ifr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire ifr_result_t  push_data,
  output logic              push_ready,
  output logic              out_valid,
  output ifr_result_t       out_data,
  input  wire logic         out_ready
);

  logic        main_vld_r;
  logic        skid_vld_r;
  ifr_result_t main_r;
  ifr_result_t skid_r;
  logic        pop;

  assign pop        = main_vld_r && out_ready;
  assign push_ready = !skid_vld_r;
  assign out_valid  = main_vld_r;
  assign out_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (push) begin
        if (!main_vld_r || (pop && !skid_vld_r)) begin
          main_vld_r <= 1'b1;
        end else if (!pop) begin
          skid_vld_r <= 1'b1;
        end
      end else if (pop) begin
        if (skid_vld_r) skid_vld_r <= 1'b0;
        else            main_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_vld_r || (pop && !skid_vld_r)) begin
        main_r <= push_data;
      end else if (pop) begin
        main_r <= skid_r;
        skid_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end else if (pop && skid_vld_r) begin
      main_r <= skid_r;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/info_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// info_frame_receiver: information frame receiver
// Results are registered in the output buffer before they reach out_ch.
// Throughput: one byte per cycle while the skid entry is free.
// A two-entry result buffer keeps input ready while one result waits.
// Reset (synchronous, rst_n low): hunting for flag, sequence 0, address 3.
// ----------------------------------------------------------------------------
module info_frame_receiver
  import ifr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  ifr_in_if.sink          in_ch,
  ifr_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  ifr_result_t core_res;
  ifr_result_t out_res;
  logic        core_vld;
  logic        in_accept;
  logic        buf_ready;

  assign in_ch.ready = buf_ready;
  assign in_accept   = in_ch.valid && buf_ready;

  ifr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (in_accept),
    .rx_byte   (in_ch.rx_byte),
    .res       (core_res),
    .res_valid (core_vld)
  );

  ifr_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept && core_vld),
    .push_data  (core_res),
    .push_ready (buf_ready),
    .out_valid  (out_ch.valid),
    .out_data   (out_res),
    .out_ready  (out_ch.ready)
  );

  assign out_ch.out_kind       = out_res.out_kind;
  assign out_ch.payload_byte   = out_res.payload_byte;
  assign out_ch.status         = out_res.status;
  assign out_ch.reply_control  = out_res.reply_control;
  assign out_ch.payload_length = out_res.payload_length;

endmodule
`default_nettype wire
